// File: rtl/wla_pkg.sv
package wla_pkg;

    // history geometry
    localparam int HISTORY_LENGTH = 24;
    localparam int SLOT_W         = (HISTORY_LENGTH > 1) ? $clog2(HISTORY_LENGTH) : 1;

    // field and accumulator widths
    localparam int COUNT_W = 16;
    localparam int LOSS_W  = 17;
    localparam int FILL_W  = 5;
    localparam int PLAIN_W = 22;
    localparam int WSUM_W  = 26;
    localparam int DENOM_W = 9;

    // shared divider geometry
    localparam int DIV_W   = 32;
    localparam int DVS_W   = 16;
    localparam int DCNT_W  = $clog2(DIV_W);

    // 1.0 in Q1.16
    localparam logic [LOSS_W-1:0] LOSS_ONE = LOSS_W'(65536);

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } div_rsp_t;

    // n(n+1)/2 for the weight total
    function automatic logic [DENOM_W-1:0] weight_total(input logic [FILL_W-1:0] n);
        logic [2*FILL_W:0] prod;
        prod = {1'b0, n} * ({1'b0, n} + (FILL_W+1)'(1));
        return DENOM_W'(prod >> 1);
    endfunction

    // saturate a quotient to 1.0
    function automatic logic [LOSS_W-1:0] clamp_loss(input logic [DIV_W-1:0] q);
        if (q > DIV_W'(LOSS_ONE)) begin
            return LOSS_ONE;
        end
        return q[LOSS_W-1:0];
    endfunction

endpackage

// File: rtl/wla_report_if.sv
interface wla_report_if;
    logic                          valid;
    logic                          ready;
    logic [wla_pkg::COUNT_W-1:0]   lost_count;
    logic [wla_pkg::COUNT_W-1:0]   expected_count;

    modport source (output valid, output lost_count, output expected_count, input ready);
    modport sink   (input valid, input lost_count, input expected_count, output ready);
endinterface

// File: rtl/wla_result_if.sv
interface wla_result_if;
    logic                          valid;
    logic                          ready;
    logic [wla_pkg::LOSS_W-1:0]    loss_average;
    logic [wla_pkg::FILL_W-1:0]    history_fill;
    logic                          updated;

    modport source (output valid, output loss_average, output history_fill, output updated,
                    input ready);
    modport sink   (input valid, input loss_average, input history_fill, input updated,
                    output ready);
endinterface

// File: rtl/weighted_loss_average.sv
// channel   dir  payload                                   beat when
// report    in   lost_count[16], expected_count[16]        valid && ready
// result    out  loss_average[17], history_fill[5],        valid && ready
//                updated[1]
//
// a report with expected_count zero skips both divisions and goes straight to
// loading the output register; any other report runs the loss fraction
// division, one sum update, one divider start, the weighted average division
// and then loads the output register, which makes its result valid
// one report in flight at a time; a finished result waits in the output
// register while the next report is already taken, and a result that still
// waits there when the next one is done stalls the sequencer and the input
// rst_n clears control and sums; history entries are only used once written
module weighted_loss_average (
    input  logic                 clk,
    input  logic                 rst_n,
    wla_report_if.sink           report,
    wla_result_if.source         result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAC_WAIT,
        ST_SUM,
        ST_AVG,
        ST_AVG_WAIT,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    logic [wla_pkg::SLOT_W-1:0]      slot_reg;
    logic [wla_pkg::FILL_W-1:0]      fill_reg;
    logic [wla_pkg::PLAIN_W-1:0]     plain_reg;
    logic [wla_pkg::WSUM_W-1:0]      wsum_reg;
    logic [wla_pkg::LOSS_W-1:0]      avg_reg;
    logic [wla_pkg::LOSS_W-1:0]      frac_reg;
    logic                            upd_reg;

    logic                            res_valid_reg;
    logic [wla_pkg::LOSS_W-1:0]      res_avg_reg;
    logic [wla_pkg::FILL_W-1:0]      res_fill_reg;
    logic                            res_upd_reg;

    logic [wla_pkg::LOSS_W-1:0]      hist_mem [wla_pkg::HISTORY_LENGTH];
    logic [wla_pkg::LOSS_W-1:0]      oldest_reg;

    wla_pkg::div_req_t               div_req;
    wla_pkg::div_rsp_t               div_rsp;

    logic                            accept;
    logic                            full;
    logic [wla_pkg::FILL_W-1:0]      n_next;
    logic [wla_pkg::WSUM_W-1:0]      wsum_next;
    logic [wla_pkg::PLAIN_W-1:0]     plain_next;
    logic                            mem_we;
    logic                            emit_go;

    wla_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign report.ready = (state_reg == ST_IDLE);
    assign accept       = report.valid && report.ready;
    assign emit_go      = (state_reg == ST_EMIT) && (!res_valid_reg || result.ready);

    // divider requests: loss fraction on the beat, average after the sum update
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {report.lost_count, wla_pkg::COUNT_W'(0)};
        div_req.divisor  = report.expected_count;
        if (accept && (report.expected_count != '0))
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == ST_AVG)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = wla_pkg::DIV_W'(wsum_reg);
            div_req.divisor  = wla_pkg::DVS_W'(wla_pkg::weight_total(fill_reg));
        end
    end

    // sum update with the oldest value dropped when the history is full
    always_comb
    begin
        full       = (fill_reg == wla_pkg::FILL_W'(wla_pkg::HISTORY_LENGTH));
        n_next     = full ? fill_reg : fill_reg + wla_pkg::FILL_W'(1);
        wsum_next  = wsum_reg - (full ? wla_pkg::WSUM_W'(plain_reg) : '0)
                   + wla_pkg::WSUM_W'(n_next) * wla_pkg::WSUM_W'(frac_reg);
        plain_next = plain_reg - (full ? wla_pkg::PLAIN_W'(oldest_reg) : '0)
                   + wla_pkg::PLAIN_W'(frac_reg);
        mem_we     = (state_reg == ST_SUM);
    end

    // history memory, read of the slot about to be overwritten on the beat
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[slot_reg] <= frac_reg;
        end
        if (accept)
        begin
            oldest_reg <= hist_mem[slot_reg];
        end
    end

    // sequencer, sums and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            plain_reg     <= '0;
            wsum_reg      <= '0;
            avg_reg       <= '0;
            upd_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        upd_reg   <= (report.expected_count != '0);
                        state_reg <= (report.expected_count != '0) ? ST_FRAC_WAIT : ST_EMIT;
                    end
                end
                ST_FRAC_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    fill_reg  <= n_next;
                    wsum_reg  <= wsum_next;
                    plain_reg <= plain_next;
                    if (slot_reg == wla_pkg::SLOT_W'(wla_pkg::HISTORY_LENGTH - 1))
                    begin
                        slot_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + wla_pkg::SLOT_W'(1);
                    end
                    state_reg <= ST_AVG;
                end
                ST_AVG:
                begin
                    state_reg <= ST_AVG_WAIT;
                end
                ST_AVG_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        avg_reg   <= wla_pkg::clamp_loss(div_rsp.quotient);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FRAC_WAIT) && div_rsp.done)
        begin
            frac_reg <= wla_pkg::clamp_loss(div_rsp.quotient);
        end
        if (emit_go)
        begin
            res_avg_reg  <= avg_reg;
            res_fill_reg <= fill_reg;
            res_upd_reg  <= upd_reg;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.loss_average = res_avg_reg;
    assign result.history_fill = res_fill_reg;
    assign result.updated      = res_upd_reg;

    // checks
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= wla_pkg::FILL_W'(wla_pkg::HISTORY_LENGTH))
        else $error("history fill beyond length");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < wla_pkg::SLOT_W'(wla_pkg::HISTORY_LENGTH))
        else $error("write slot beyond history");

    a_upd_fill: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.updated |-> result.history_fill != '0)
        else $error("updated result with empty history");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        avg_reg <= wla_pkg::LOSS_ONE)
        else $error("average above one");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_FRAC_WAIT || state_reg == ST_AVG_WAIT))
        else $error("divider finished with no request pending");

endmodule

// File: rtl/wla_div.sv
module wla_div (
    input  logic               clk,
    input  logic               rst_n,
    input  wla_pkg::div_req_t  req,
    output wla_pkg::div_rsp_t  rsp
);

    logic [wla_pkg::DVS_W-1:0]  rem_reg;
    logic [wla_pkg::DIV_W-1:0]  quo_reg;
    logic [wla_pkg::DVS_W-1:0]  dvs_reg;
    logic [wla_pkg::DCNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [wla_pkg::DVS_W:0]    rem_shift;
    logic [wla_pkg::DVS_W-1:0]  rem_diff;
    logic                       fits;

    // one restoring step per cycle while busy
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[wla_pkg::DIV_W-1]};
        rem_diff  = rem_shift[wla_pkg::DVS_W-1:0] - dvs_reg;
        fits      = rem_shift >= {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start
                     && (cnt_reg == wla_pkg::DCNT_W'(wla_pkg::DIV_W - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + wla_pkg::DCNT_W'(1);
                if (cnt_reg == wla_pkg::DCNT_W'(wla_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff : rem_shift[wla_pkg::DVS_W-1:0];
            quo_reg <= {quo_reg[wla_pkg::DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
